// ----- rtl/rria_pkg.sv -----
`default_nettype none
package rria_pkg;

   // default size of the identifier space
   localparam int unsigned ID_COUNT_DEFAULT = 256;

   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned ID_W     = 8;

   // request opcodes, code 3 is unused and ignored
   localparam logic [OPCODE_W-1:0] OP_RESET = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_MARK  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_NEXT  = 2'd2;

endpackage
`default_nettype wire

// ----- rtl/round_robin_id_allocator_unit.sv -----
`default_nettype none
// mark beat: sets the given id used in the used-map ram when taken; the unit stays in idle
// reset beat: one clearing sweep of the used-map ram, one entry per cycle
// allocate beat: one candidate id checked per cycle through the
//    single read port of the used-map ram; worst case checks every id but the last one given
// hardware reset runs the same clearing sweep (leaving id 0 used)
//    before the first request beat is taken
module round_robin_id_allocator_unit
   import rria_pkg::*;
#(
   parameter int unsigned ID_COUNT = ID_COUNT_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire  [OPCODE_W-1:0] req_opcode,
   input  wire  [ID_W-1:0]     req_id,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [ID_W-1:0]     rsp_allocated_id,
   output logic                rsp_none_free
);

   // width of an internal identifier
   localparam int unsigned IW = $clog2(ID_COUNT);
   localparam logic [IW-1:0] LAST_ID = IW'(ID_COUNT - 1);
   // candidates still to issue after the first one of a scan
   localparam logic [IW-1:0] SCAN_LEFT_INIT = IW'(ID_COUNT - 2);
   localparam logic SCAN_ONE_CAND = (ID_COUNT == 2);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN
   } state_type;

   // circular successor of an id
   function automatic logic [IW-1:0] next_id(input logic [IW-1:0] v);
      logic [IW-1:0] r;
      if (v == LAST_ID) begin
         r = '0;
      end else begin
         r = v + IW'(1);
      end
      return r;
   endfunction

   state_type     state_ff;
   logic [IW-1:0] last_given_ff;
   logic [IW-1:0] clr_addr_ff;   // sweep pointer
   logic [IW-1:0] set_id_ff;     // id left marked at the end of the sweep
   logic [IW-1:0] cand_ff;       // next candidate to read
   logic [IW-1:0] left_ff;       // candidates not yet read
   logic [IW-1:0] chk_id_ff;     // candidate whose used bit sits in rd_data_ff
   logic          chk_last_ff;   // that candidate closes the circle
   logic          rsp_valid_ff;
   logic [ID_W-1:0] rsp_id_ff;
   logic          rsp_none_ff;

   // used-map ram, one bit per id
   logic          used_mem [ID_COUNT];
   logic          rd_data_ff;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic          wr_data;

   logic          out_free;
   logic          req_take;
   logic          id_in_range;
   logic [31:0]   req_id_wide;
   logic [IW-1:0] req_idx;
   logic [IW-1:0] first_cand;
   logic [31:0]   chk_id_wide;

   assign req_id_wide = 32'(req_id);
   assign req_idx     = req_id_wide[IW-1:0];
   assign id_in_range = req_id_wide < 32'(ID_COUNT);
   assign first_cand  = next_id(last_given_ff);
   assign chk_id_wide = 32'(chk_id_ff);

   // output slot is free, or is emptied this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // an allocate beat only starts once its result has somewhere to go
   assign req_stall = (state_ff != S_IDLE) || ((req_opcode == OP_NEXT) && !out_free);
   assign req_take  = req_valid && !req_stall;

   // read address: first candidate at the start, then the scan pointer
   always_comb begin
      if (state_ff == S_SCAN) begin
         rd_addr = cand_ff;
      end else begin
         rd_addr = first_cand;
      end
   end

   // write port: sweep, mark, or claim of a found id
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_addr_ff;
      wr_data = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = (clr_addr_ff == set_id_ff);
         end
         S_IDLE: begin
            wr_en   = req_take && (req_opcode == OP_MARK) && id_in_range;
            wr_addr = req_idx;
            wr_data = 1'b1;
         end
         S_SCAN: begin
            wr_en   = !rd_data_ff;
            wr_addr = chk_id_ff;
            wr_data = 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         used_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= used_mem[rd_addr];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         last_given_ff <= '0;
         clr_addr_ff   <= '0;
         set_id_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= next_id(clr_addr_ff);
               if (clr_addr_ff == LAST_ID) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_take) begin
                  if ((req_opcode == OP_RESET) && id_in_range) begin
                     // clear everything, leave the given id used and last
                     set_id_ff     <= req_idx;
                     last_given_ff <= req_idx;
                     clr_addr_ff   <= '0;
                     state_ff      <= S_CLEAR;
                  end else if (req_opcode == OP_NEXT) begin
                     // first candidate read goes out on this edge
                     chk_id_ff   <= first_cand;
                     chk_last_ff <= SCAN_ONE_CAND;
                     cand_ff     <= next_id(first_cand);
                     left_ff     <= SCAN_LEFT_INIT;
                     state_ff    <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (!rd_data_ff) begin
                  // free id found: claim it and hand it out
                  last_given_ff <= chk_id_ff;
                  rsp_id_ff     <= chk_id_wide[ID_W-1:0];
                  rsp_none_ff   <= 1'b0;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else if (chk_last_ff) begin
                  // full circle, nothing free
                  rsp_id_ff    <= '0;
                  rsp_none_ff  <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  chk_id_ff   <= cand_ff;
                  chk_last_ff <= (left_ff == IW'(1));
                  left_ff     <= left_ff - IW'(1);
                  cand_ff     <= next_id(cand_ff);
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_allocated_id = rsp_id_ff;
   assign rsp_none_free    = rsp_none_ff;

endmodule
`default_nettype wire
